// ===== sv/assert_macros.svh =====
// assertion helpers shared by the scanner rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SQLTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define SQLTS_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== sv/sqlts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqlts_pkg
// Shared types and constants of the sql token scanner: token record, scan
// modes, token kinds, keyword and punctuation tables, character classes.
// ----------------------------------------------------------------------------
package sqlts_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_WORD,
      MODE_NUMBER,
      MODE_STRING
   } scan_mode_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic        last;
   } token_type;

   localparam logic [4:0] KIND_END          = 5'd0;
   localparam logic [4:0] KIND_IDENT        = 5'd1;
   localparam logic [4:0] KIND_NUMBER       = 5'd2;
   localparam logic [4:0] KIND_STRING       = 5'd3;
   localparam logic [4:0] KIND_KEYWORD_BASE = 5'd4;
   localparam logic [4:0] KIND_PUNCT_BASE   = 5'd25;

   localparam logic [7:0] CHAR_NUL        = 8'h00;
   localparam logic [7:0] CHAR_QUOTE      = 8'h22;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;

   localparam int KEYWORD_COUNT = 21;
   localparam int PUNCT_COUNT   = 7;

   // keyword text right-aligned, first character in the highest used byte
   localparam logic [63:0] KEYWORD_PACKED [KEYWORD_COUNT] = '{
      64'("CREATE"), 64'("TABLE"),  64'("INSERT"),  64'("INTO"),
      64'("VALUES"), 64'("SELECT"), 64'("FROM"),    64'("JOIN"),
      64'("ON"),     64'("WHERE"),  64'("DELETE"),  64'("UPDATE"),
      64'("SET"),    64'("PRIMARY"), 64'("KEY"),    64'("UNIQUE"),
      64'("INT"),    64'("TEXT"),   64'("BOOL"),    64'("TRUE"),
      64'("FALSE")
   };

   localparam logic [7:0] PUNCT_BYTES [PUNCT_COUNT] = '{
      8'h2e, 8'h2a, 8'h2c, 8'h28, 8'h29, 8'h3d, 8'h3b
   };

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

endpackage

// ===== sv/sql_token_scanner_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sql_token_scanner_unit
// Splits sql query text into tokens (kind, start offset, length).
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one text byte per request, byte 0 closes the query and
//   restarts offsets at 0 for the next one.
//   rsp channel: one token per transfer; rsp_last marks the end token made
//   by byte 0. A byte yields zero, one or two tokens.
//   A request lands in the input register when it is accepted; once the queue
//   has room it is scanned, its tokens enter the result queue, and the first
//   of them is offered on rsp.
//   Throughput: one byte per cycle. The four-entry result queue accepts a
//   scan only with two free slots; tokens average at most one per byte, so
//   while rsp is not stalled the queue never holds up the input.
//   rsp_stall holds the head token; req_stall rises once the queue has no
//   room for a scan and the input register is full.
//   Reset clears the scan state, offsets and the result queue.
// ----------------------------------------------------------------------------
module sql_token_scanner_unit #(
   parameter int POSITION_BITS     = 16,
   parameter int KEYWORD_MAX_CHARS = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last
);
   import sqlts_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       room;
   logic       consume;
   logic       load;
   logic       close_valid, open_valid;
   token_type  close_token, open_token, head_token;

   assign consume   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign load      = req_valid && !req_stall;

   assign in_valid_in = load | (in_valid_ff & !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_byte_ff <= req_text_byte;
      end
   end

   sqlts_scan #(
      .POSITION_BITS     (POSITION_BITS),
      .KEYWORD_MAX_CHARS (KEYWORD_MAX_CHARS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .step        (consume),
      .text_byte   (in_byte_ff),
      .close_valid (close_valid),
      .close_token (close_token),
      .open_valid  (open_valid),
      .open_token  (open_token)
   );

   sqlts_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push_a    (consume && close_valid),
      .token_a   (close_token),
      .push_b    (consume && open_valid),
      .token_b   (open_token),
      .room      (room),
      .out_valid (rsp_valid),
      .out_token (head_token),
      .out_stall (rsp_stall)
   );

   assign rsp_token_kind   = head_token.kind;
   assign rsp_token_start  = head_token.start;
   assign rsp_token_length = head_token.length;
   assign rsp_last         = head_token.last;

endmodule

// ===== sv/sqlts_scan.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// sqlts_scan
// Scanner state and the single-pass token logic. For each byte it steps the
// state and offers up to two tokens: one closing the open token, one new.
// ----------------------------------------------------------------------------
module sqlts_scan #(
   parameter int POSITION_BITS     = 16,
   parameter int KEYWORD_MAX_CHARS = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          text_byte,
   output logic                close_valid,
   output sqlts_pkg::token_type close_token,
   output logic                open_valid,
   output sqlts_pkg::token_type open_token
);
   import sqlts_pkg::*;

   localparam int PB = POSITION_BITS;
   localparam int WW = 8 * KEYWORD_MAX_CHARS;
   localparam int EW = (PB > 16) ? PB : 16;
   localparam logic [PB-1:0] POS_MAX = '1;
   localparam int SAT16 = 65535;

   scan_mode_type  mode_ff, mode_in;
   logic [PB-1:0]  pos_ff, pos_in;
   logic [PB-1:0]  origin_ff, origin_in;
   logic [WW-1:0]  window_ff, window_in;
   logic           too_long_ff, too_long_in;

   logic [PB-1:0]  cur_inc;
   logic [PB-1:0]  span;
   logic [4:0]     word_kind;
   logic [4:0]     punct_kind;
   logic           is_punct;
   logic           fall;

   function automatic logic [15:0] sat16(input logic [PB-1:0] v);
      logic [EW-1:0] e;
      e = EW'(v);
      return (e > EW'(SAT16)) ? 16'hffff : e[15:0];
   endfunction

   assign cur_inc = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
   assign span    = pos_ff - origin_ff;

   always_comb begin
      word_kind = KIND_IDENT;
      if (!too_long_ff) begin
         for (int i = 0; i < KEYWORD_COUNT; i++) begin
            if (window_ff == WW'(KEYWORD_PACKED[i])) begin
               word_kind = KIND_KEYWORD_BASE + 5'(i);
            end
         end
      end
   end

   always_comb begin
      is_punct   = 1'b0;
      punct_kind = KIND_END;
      for (int i = 0; i < PUNCT_COUNT; i++) begin
         if (text_byte == PUNCT_BYTES[i]) begin
            is_punct   = 1'b1;
            punct_kind = KIND_PUNCT_BASE + 5'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         pos_ff      <= '0;
         origin_ff   <= '0;
         window_ff   <= '0;
         too_long_ff <= 1'b0;
      end else if (step) begin
         mode_ff     <= mode_in;
         pos_ff      <= pos_in;
         origin_ff   <= origin_in;
         window_ff   <= window_in;
         too_long_ff <= too_long_in;
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      pos_in      = cur_inc;
      origin_in   = origin_ff;
      window_in   = window_ff;
      too_long_in = too_long_ff;
      close_valid = 1'b0;
      open_valid  = 1'b0;
      close_token = '{kind: KIND_IDENT, start: sat16(origin_ff), length: sat16(span),
                      last: 1'b0};
      open_token  = '{kind: KIND_END, start: sat16(pos_ff), length: 16'd1, last: 1'b0};
      fall        = 1'b1;

      unique case (mode_ff)
         MODE_STRING: begin
            if (text_byte == CHAR_QUOTE || text_byte == CHAR_NUL) begin
               close_valid      = 1'b1;
               close_token.kind = KIND_STRING;
               mode_in          = MODE_IDLE;
            end
            fall = (text_byte == CHAR_NUL);
         end
         MODE_WORD: begin
            if (is_letter(text_byte) || is_digit(text_byte) ||
                text_byte == CHAR_UNDERSCORE) begin
               if (window_ff[WW-1 -: 8] != 8'h00) begin
                  too_long_in = 1'b1;
               end
               window_in = {window_ff[WW-9:0], text_byte};
               fall      = 1'b0;
            end else begin
               close_valid      = 1'b1;
               close_token.kind = word_kind;
               mode_in          = MODE_IDLE;
            end
         end
         MODE_NUMBER: begin
            if (is_digit(text_byte)) begin
               fall = 1'b0;
            end else begin
               close_valid      = 1'b1;
               close_token.kind = KIND_NUMBER;
               mode_in          = MODE_IDLE;
            end
         end
         MODE_IDLE: begin
            fall = 1'b1;
         end
         default: begin
            fall = 1'b1;
         end
      endcase

      if (fall && !is_space(text_byte)) begin
         if (text_byte == CHAR_NUL) begin
            open_valid         = 1'b1;
            open_token.length  = 16'd0;
            open_token.last    = 1'b1;
            mode_in            = MODE_IDLE;
            pos_in             = '0;
            origin_in          = '0;
            window_in          = '0;
            too_long_in        = 1'b0;
         end else if (is_letter(text_byte)) begin
            mode_in     = MODE_WORD;
            origin_in   = pos_ff;
            window_in   = WW'(text_byte);
            too_long_in = 1'b0;
         end else if (is_digit(text_byte)) begin
            mode_in   = MODE_NUMBER;
            origin_in = pos_ff;
         end else if (text_byte == CHAR_QUOTE) begin
            mode_in   = MODE_STRING;
            origin_in = cur_inc;
         end else if (is_punct) begin
            open_valid      = 1'b1;
            open_token.kind = punct_kind;
         end else begin
            open_valid = 1'b1;
         end
      end
   end

   `SQLTS_ASSERT(a_last_is_end, clock, reset, !(open_valid && open_token.last) || (open_token.kind == KIND_END && open_token.length == 16'd0), "last token must be an empty end token")
   `SQLTS_ASSERT(a_restart_after_end, clock, reset, (step && text_byte == CHAR_NUL) |=> (pos_ff == '0 && mode_ff == MODE_IDLE), "end of input must restart the scan")
   `SQLTS_NEVER(a_close_needs_token, clock, reset, close_valid && mode_ff == MODE_IDLE, "token closed while no token was open")

endmodule

// ===== sv/sqlts_rsp_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// sqlts_rsp_queue
// Four-entry result queue. Takes up to two tokens per cycle, in order, and
// hands out one per cycle on the valid/stall response channel unless stalled.
// ----------------------------------------------------------------------------
module sqlts_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_a,
   input  sqlts_pkg::token_type token_a,
   input  logic                 push_b,
   input  sqlts_pkg::token_type token_b,
   output logic                 room,
   output logic                 out_valid,
   output sqlts_pkg::token_type out_token,
   input  logic                 out_stall
);
   import sqlts_pkg::*;

   localparam int DEPTH = 4;

   token_type  entry_ff [DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] push_cnt;
   logic       pop;
   token_type  first_token;

   assign push_cnt    = 2'(push_a) + 2'(push_b);
   assign pop         = (count_ff != 3'd0) && !out_stall;
   assign first_token = push_a ? token_a : token_b;
   assign room        = count_ff <= 3'(DEPTH - 2);
   assign out_valid   = count_ff != 3'd0;
   assign out_token   = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + push_cnt;
   assign rd_ptr_in = rd_ptr_ff + 2'(pop);
   assign count_in  = count_ff + 3'(push_cnt) - 3'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // two writes in one cycle go to consecutive slots
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         entry_ff[wr_ptr_ff] <= first_token;
      end
      if (push_a && push_b) begin
         entry_ff[wr_ptr_ff + 2'd1] <= token_b;
      end
   end

   `SQLTS_NEVER(a_no_overflow, clock, reset, push_cnt != 2'd0 && count_ff > 3'(DEPTH - 2), "push into queue without room")
   `SQLTS_ASSERT(a_count_tracks, clock, reset, count_ff <= 3'(DEPTH) && ((wr_ptr_ff - rd_ptr_ff) == count_ff[1:0]), "queue count out of step with pointers")

endmodule
